[rtl/core/plt_pkg.sv]
// Package with the shared codes and default sizes of the packet loss tracker.
`timescale 1ns / 1ps
package plt_pkg;

   localparam int LOSS_DEPTH_DEF   = 1024;
   localparam int RESEND_BATCH_DEF = 63;
   localparam int MAX_RESULTS      = 64;

   localparam logic [1:0] FUNC_PACKET = 2'd0;
   localparam logic [1:0] FUNC_TICK   = 2'd1;
   localparam logic [1:0] FUNC_START  = 2'd2;

   localparam logic [2:0] KIND_PLACE     = 3'd0;
   localparam logic [2:0] KIND_PROGRESS  = 3'd1;
   localparam logic [2:0] KIND_DONE      = 3'd2;
   localparam logic [2:0] KIND_FAILED    = 3'd3;
   localparam logic [2:0] KIND_RESEND    = 3'd4;
   localparam logic [2:0] KIND_RECONNECT = 3'd5;

   localparam logic [1:0] CSR_TIMEOUT_TICKS = 2'd0;
   localparam logic [1:0] CSR_MAX_ROUNDS    = 2'd1;

   localparam logic [15:0] TIMEOUT_RESET    = 16'd5000;
   localparam logic [3:0]  MAX_ROUNDS_RESET = 4'd5;
   localparam logic [7:0]  PERCENT_NONE     = 8'd255;
   localparam logic [4:0]  ROUND_NONE       = 5'd31;
   localparam logic [4:0]  ROUND_MAX        = 5'd30;

endpackage

[rtl/core/packet_loss_tracker_core.sv]
// Packet loss tracker: receive-side loss list, progress and resend control.
//
//  Channel | Direction | Ports                                   | Handshake
//  req     | in        | req_func, req_seq, req_total            | valid / ready
//  rsp     | out       | rsp_kind, rsp_value, rsp_last, rsp_overflow | valid / ready
//  csr     | in        | csr_index, csr_data                     | csr_we only
//
// One transaction is worked on at a time; req_ready is high only while the sequencer idles.
// A packet first appends its gap numbers to the loss list, then works out the percentage;
// in resend mode the loss list is scanned and compacted entry by entry through the
// single list memory before the percentage is worked out.
// A timeout emits its resend entries one by one (memory read, then output register).
// Reset is synchronous; the loss list memory needs no clearing pass.
// A stalled result waits in the output register; the sequencer holds until it is taken.
`timescale 1ns / 1ps
module packet_loss_tracker_core #(
   parameter int LOSS_DEPTH   = plt_pkg::LOSS_DEPTH_DEF,
   parameter int RESEND_BATCH = plt_pkg::RESEND_BATCH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_func,
   input  logic [15:0] req_seq,
   input  logic [15:0] req_total,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [15:0] rsp_value,
   output logic        rsp_last,
   output logic        rsp_overflow,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int AW = (LOSS_DEPTH > 1) ? $clog2(LOSS_DEPTH) : 1;
   localparam int CW = $clog2(LOSS_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(LOSS_DEPTH);

   localparam logic [4:0] S_IDLE    = 5'd0;
   localparam logic [4:0] S_GAP     = 5'd1;
   localparam logic [4:0] S_PCT     = 5'd2;
   localparam logic [4:0] S_DIV     = 5'd3;
   localparam logic [4:0] S_EM_PL   = 5'd4;
   localparam logic [4:0] S_EM_PR   = 5'd5;
   localparam logic [4:0] S_EM_F1   = 5'd6;
   localparam logic [4:0] S_EM_F2   = 5'd7;
   localparam logic [4:0] S_EM_FAIL = 5'd8;
   localparam logic [4:0] S_TICK2   = 5'd9;
   localparam logic [4:0] S_EM_REC  = 5'd10;
   localparam logic [4:0] S_RS_RD   = 5'd11;
   localparam logic [4:0] S_RS_EM   = 5'd12;
   localparam logic [4:0] S_SR_RD   = 5'd13;
   localparam logic [4:0] S_SR_CMP  = 5'd14;
   localparam logic [4:0] S_MV_RD   = 5'd15;
   localparam logic [4:0] S_MV_WR   = 5'd16;

   logic [4:0]    state_ff, state_in;
   logic [15:0]   tmo_ff, tmo_in;
   logic [3:0]    maxr_ff, maxr_in;
   logic [15:0]   tp_ff, tp_in;
   logic [15:0]   lr_ff, lr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          resend_ff, resend_in;
   logic [15:0]   resent_ff, resent_in;
   logic [15:0]   ltot_ff, ltot_in;
   logic [7:0]    prev_ff, prev_in;
   logic [4:0]    round_ff, round_in;
   logic [15:0]   idle_ff, idle_in;
   logic          armed_ff, armed_in;
   logic          ovf_ff, ovf_in;
   logic [15:0]   seq_ff, seq_in;
   logic [16:0]   cur_ff, cur_in;
   logic [16:0]   end_ff, end_in;
   logic          tickm_ff, tickm_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [7:0]    n_ff, n_in;
   logic [6:0]    p_ff, p_in;
   logic [22:0]   rem_ff, rem_in;
   logic [2:0]    bit_ff, bit_in;
   logic          fin_ff, fin_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_kind_ff, rsp_kind_in;
   logic [15:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic [15:0]   loss_mem_ff [LOSS_DEPTH];
   logic [15:0]   rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [15:0]   mem_wd;
   logic [AW-1:0] mem_ra;

   logic          out_free;
   logic          emit_en;
   logic [2:0]    emit_kind;
   logic [15:0]   emit_value;
   logic          emit_last;
   logic          accept;

   logic [15:0]   idle_n;
   logic [15:0]   limit;
   logic signed [18:0] num;
   logic [22:0]   dv;
   logic [16:0]   nb;
   logic [16:0]   room;
   logic [16:0]   nsel;
   logic          recon;
   logic [15:0]   tp_new;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      tmo_in    = tmo_ff;
      maxr_in   = maxr_ff;
      tp_in     = tp_ff;
      lr_in     = lr_ff;
      count_in  = count_ff;
      resend_in = resend_ff;
      resent_in = resent_ff;
      ltot_in   = ltot_ff;
      prev_in   = prev_ff;
      round_in  = round_ff;
      idle_in   = idle_ff;
      armed_in  = armed_ff;
      ovf_in    = ovf_ff;
      seq_in    = seq_ff;
      cur_in    = cur_ff;
      end_in    = end_ff;
      tickm_in  = tickm_ff;
      idx_in    = idx_ff;
      n_in      = n_ff;
      p_in      = p_ff;
      rem_in    = rem_ff;
      bit_in    = bit_ff;
      fin_in    = fin_ff;
      mem_we    = 1'b0;
      mem_wa    = count_ff[AW-1:0];
      mem_wd    = cur_ff[15:0];
      mem_ra    = idx_ff[AW-1:0];
      emit_en    = 1'b0;
      emit_kind  = plt_pkg::KIND_PLACE;
      emit_value = 16'd0;
      emit_last  = 1'b0;

      idle_n = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;
      limit  = (tmo_ff == 16'd0) ? 16'd1 : tmo_ff;
      tp_new = (tp_ff == 16'd0) ? req_total : tp_ff;
      if (resend_ff) begin
         num = 19'(tp_ff) + 19'(resent_ff) - 19'(ltot_ff);
      end else begin
         num = 19'(seq_ff) - 19'(count_ff);
      end
      dv    = 23'(tp_ff) << bit_ff;
      recon = (round_ff >= {1'b0, maxr_ff});
      nb    = (17'(count_ff) < 17'(RESEND_BATCH)) ? 17'(count_ff) : 17'(RESEND_BATCH);
      room  = recon ? 17'(plt_pkg::MAX_RESULTS - 1) : 17'(plt_pkg::MAX_RESULTS);
      nsel  = (nb > room) ? room : nb;

      if (csr_we) begin
         if (csr_index == plt_pkg::CSR_TIMEOUT_TICKS) begin
            tmo_in = csr_data;
         end else if (csr_index == plt_pkg::CSR_MAX_ROUNDS) begin
            maxr_in = csr_data[3:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               seq_in = req_seq;
               if (req_func == plt_pkg::FUNC_PACKET) begin
                  armed_in = 1'b1;
                  idle_in  = 16'd0;
                  tp_in    = tp_new;
                  if (req_seq != 16'd0) begin
                     if (resend_ff) begin
                        idx_in   = '0;
                        state_in = S_SR_RD;
                     end else begin
                        lr_in    = req_seq;
                        cur_in   = 17'(lr_ff) + 17'd1;
                        end_in   = 17'(req_seq);
                        tickm_in = 1'b0;
                        state_in = S_GAP;
                     end
                  end
               end else if (req_func == plt_pkg::FUNC_TICK) begin
                  if (armed_ff) begin
                     idle_in = idle_n;
                     if (idle_n >= limit) begin
                        if (tp_ff == 16'd0) begin
                           state_in = S_EM_FAIL;
                        end else if (round_ff == plt_pkg::ROUND_NONE) begin
                           // First timeout: everything past the last packet is lost.
                           round_in = 5'd0;
                           cur_in   = 17'(lr_ff) + 17'd1;
                           end_in   = 17'(tp_ff) + 17'd1;
                           tickm_in = 1'b1;
                           state_in = S_GAP;
                        end else begin
                           if (round_ff < plt_pkg::ROUND_MAX) begin
                              round_in = round_ff + 5'd1;
                           end
                           state_in = S_TICK2;
                        end
                     end
                  end
               end else if (req_func == plt_pkg::FUNC_START) begin
                  tp_in     = 16'd0;
                  lr_in     = 16'd0;
                  count_in  = '0;
                  resend_in = 1'b0;
                  resent_in = 16'd0;
                  ltot_in   = 16'd0;
                  prev_in   = plt_pkg::PERCENT_NONE;
                  round_in  = plt_pkg::ROUND_NONE;
                  idle_in   = 16'd0;
                  armed_in  = 1'b0;
                  ovf_in    = 1'b0;
               end
            end
         end
         S_GAP: begin
            if (cur_ff < end_ff) begin
               if (count_ff < DEPTH_C) begin
                  mem_we   = 1'b1;
                  count_in = count_ff + CW'(1);
                  cur_in   = cur_ff + 17'd1;
               end else begin
                  // List full: the rest of the gap is dropped at once.
                  ovf_in   = 1'b1;
                  state_in = tickm_ff ? S_TICK2 : S_PCT;
               end
            end else begin
               state_in = tickm_ff ? S_TICK2 : S_PCT;
            end
         end
         S_PCT: begin
            fin_in = resend_ff ? (resent_ff == ltot_ff)
                               : ((seq_ff == tp_ff) && (count_ff == '0));
            p_in   = 7'd0;
            if (tp_ff == 16'd0 || num[18] || num == 19'sd0) begin
               state_in = S_EM_PL;
            end else if (num >= 19'(tp_ff)) begin
               p_in     = 7'd100;
               state_in = S_EM_PL;
            end else begin
               rem_in   = 23'(num[15:0]) * 23'd100;
               bit_in   = 3'd6;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_ff >= dv) begin
               rem_in        = rem_ff - dv;
               p_in[bit_ff]  = 1'b1;
            end
            if (bit_ff == 3'd0) begin
               state_in = S_EM_PL;
            end else begin
               bit_in = bit_ff - 3'd1;
            end
         end
         S_EM_PL: begin
            if (out_free) begin
               prev_in    = {1'b0, p_ff};
               emit_en    = 1'b1;
               emit_kind  = plt_pkg::KIND_PLACE;
               emit_value = seq_ff - 16'd1;
               emit_last  = !(({1'b0, p_ff} != prev_ff) || fin_ff);
               if ({1'b0, p_ff} != prev_ff) begin
                  state_in = S_EM_PR;
               end else begin
                  state_in = fin_ff ? S_EM_F1 : S_IDLE;
               end
            end
         end
         S_EM_PR: begin
            if (out_free) begin
               emit_en    = 1'b1;
               emit_kind  = plt_pkg::KIND_PROGRESS;
               emit_value = 16'(p_ff);
               emit_last  = !fin_ff;
               state_in   = fin_ff ? S_EM_F1 : S_IDLE;
            end
         end
         S_EM_F1: begin
            if (out_free) begin
               emit_en    = 1'b1;
               emit_kind  = plt_pkg::KIND_PROGRESS;
               emit_value = 16'd100;
               state_in   = S_EM_F2;
            end
         end
         S_EM_F2: begin
            if (out_free) begin
               emit_en    = 1'b1;
               emit_kind  = plt_pkg::KIND_DONE;
               emit_value = 16'd100;
               emit_last  = 1'b1;
               armed_in   = 1'b0;
               state_in   = S_IDLE;
            end
         end
         S_EM_FAIL: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_kind = plt_pkg::KIND_FAILED;
               emit_last = 1'b1;
               armed_in  = 1'b0;
               state_in  = S_IDLE;
            end
         end
         S_TICK2: begin
            if (count_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               if (recon) begin
                  round_in = 5'd0;
               end
               if (ltot_ff == 16'd0) begin
                  ltot_in = 16'(count_ff);
               end
               n_in      = nsel[7:0];
               idx_in    = '0;
               resend_in = 1'b1;
               idle_in   = 16'd0;
               state_in  = recon ? S_EM_REC : S_RS_RD;
            end
         end
         S_EM_REC: begin
            if (out_free) begin
               emit_en   = 1'b1;
               emit_kind = plt_pkg::KIND_RECONNECT;
               state_in  = S_RS_RD;
            end
         end
         S_RS_RD: begin
            state_in = S_RS_EM;
         end
         S_RS_EM: begin
            if (out_free) begin
               emit_en    = 1'b1;
               emit_kind  = plt_pkg::KIND_RESEND;
               emit_value = rd_data_ff;
               emit_last  = (17'(idx_ff) + 17'd1 == 17'(n_ff));
               idx_in     = idx_ff + CW'(1);
               state_in   = (17'(idx_ff) + 17'd1 == 17'(n_ff)) ? S_IDLE : S_RS_RD;
            end
         end
         S_SR_RD: begin
            if (idx_ff < count_ff) begin
               state_in = S_SR_CMP;
            end else if (resent_ff == ltot_ff) begin
               fin_in   = 1'b1;
               state_in = S_EM_F1;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SR_CMP: begin
            if (rd_data_ff == seq_ff) begin
               resent_in = resent_ff + 16'd1;
               state_in  = S_MV_RD;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = S_SR_RD;
            end
         end
         S_MV_RD: begin
            // Close the hole: each later entry moves down by one place.
            mem_ra = AW'(idx_ff + CW'(1));
            if (idx_ff + CW'(1) < count_ff) begin
               state_in = S_MV_WR;
            end else begin
               count_in = count_ff - CW'(1);
               state_in = S_PCT;
            end
         end
         S_MV_WR: begin
            mem_we = 1'b1;
            mem_wa = idx_ff[AW-1:0];
            mem_wd = rd_data_ff;
            idx_in = idx_ff + CW'(1);
            state_in = S_MV_RD;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit_en) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = emit_kind;
         rsp_value_in = emit_value;
         rsp_last_in  = emit_last;
         rsp_ovf_in   = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         loss_mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= loss_mem_ff[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tmo_ff       <= plt_pkg::TIMEOUT_RESET;
         maxr_ff      <= plt_pkg::MAX_ROUNDS_RESET;
         tp_ff        <= 16'd0;
         lr_ff        <= 16'd0;
         count_ff     <= '0;
         resend_ff    <= 1'b0;
         resent_ff    <= 16'd0;
         ltot_ff      <= 16'd0;
         prev_ff      <= plt_pkg::PERCENT_NONE;
         round_ff     <= plt_pkg::ROUND_NONE;
         idle_ff      <= 16'd0;
         armed_ff     <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tmo_ff       <= tmo_in;
         maxr_ff      <= maxr_in;
         tp_ff        <= tp_in;
         lr_ff        <= lr_in;
         count_ff     <= count_in;
         resend_ff    <= resend_in;
         resent_ff    <= resent_in;
         ltot_ff      <= ltot_in;
         prev_ff      <= prev_in;
         round_ff     <= round_in;
         idle_ff      <= idle_in;
         armed_ff     <= armed_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      seq_ff       <= seq_in;
      cur_ff       <= cur_in;
      end_ff       <= end_in;
      tickm_ff     <= tickm_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      p_ff         <= p_in;
      rem_ff       <= rem_in;
      bit_ff       <= bit_in;
      fin_ff       <= fin_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = rsp_kind_ff;
   assign rsp_value    = rsp_value_ff;
   assign rsp_last     = rsp_last_ff;
   assign rsp_overflow = rsp_ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("loss count exceeds list depth");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_en |-> out_free)
      else $error("result produced while output register is occupied");

   a_write_bound: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_wa) < count_ff || (state_ff == S_GAP && count_ff < DEPTH_C)))
      else $error("loss list written outside its filled range");

   a_round_kept: assert property (@(posedge clock) disable iff (reset)
      (round_ff != plt_pkg::ROUND_NONE && !(accept && req_func == plt_pkg::FUNC_START))
      |=> round_ff != plt_pkg::ROUND_NONE)
      else $error("round count returned to the no-timeout code");

endmodule

[test/tb_packet_loss_tracker_core.sv]
// Self-checking testbench of the packet loss tracker core with its own loss-list tracker.
`timescale 1ns / 1ps
module tb_packet_loss_tracker_core;

   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   typedef struct {
      logic [2:0]  kind;
      logic [15:0] value;
      logic        last;
      logic        overflow;
   } result_type;

   typedef struct {
      logic [1:0]  func;
      logic [15:0] seq;
      logic [15:0] total;
      bit          fixed;
      int          n_fixed;
      logic [2:0]  kind;
      logic [15:0] value;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_func;
   logic [15:0] req_seq;
   logic [15:0] req_total;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [2:0]  rsp_kind;
   logic [15:0] rsp_value;
   logic        rsp_last;
   logic        rsp_overflow;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_data;

   packet_loss_tracker_core dut (.*);

   // Tracker state, kept at the widths of the block but for the loss count.
   logic [15:0] timeout_reg;
   logic [3:0]  rounds_reg;
   logic [15:0] total_pk;
   logic [15:0] last_rx;
   logic [15:0] loss_mem [0:plt_pkg::LOSS_DEPTH_DEF-1];
   int          loss_n;
   bit          resend_on;
   logic [15:0] resent_n;
   logic [15:0] loss_tot;
   logic [7:0]  prev_pct;
   logic [4:0]  round_n;
   logic [15:0] idle_n;
   bit          armed;
   bit          ovf;

   result_type  step_q[$];
   result_type  expected_q[$];
   row_type     rows[$];
   int          errors;
   int          burst_left;
   int          items_sent;
   bit          pressure_req;
   int          hold_cnt;
   int          stall_mode;
   int          mode_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("packet_loss_tracker_core: mismatch");
      $finish;
   end

   function automatic void session_clear();
      total_pk  = '0;
      last_rx   = '0;
      loss_n    = 0;
      resend_on = 0;
      resent_n  = '0;
      loss_tot  = '0;
      prev_pct  = plt_pkg::PERCENT_NONE;
      round_n   = plt_pkg::ROUND_NONE;
      idle_n    = '0;
      armed     = 0;
      ovf       = 0;
   endfunction

   function automatic void put(logic [2:0] kind, logic [15:0] value);
      result_type r;
      if (step_q.size() >= plt_pkg::MAX_RESULTS) return;
      r.kind     = kind;
      r.value    = value;
      r.last     = 0;
      r.overflow = 0;
      step_q.insert(step_q.size(), r);
   endfunction

   function automatic void note_loss(int s);
      if (loss_n < plt_pkg::LOSS_DEPTH_DEF) begin
         loss_mem[loss_n] = s[15:0];
         loss_n++;
      end else begin
         ovf = 1;
      end
   endfunction

   function automatic logic [7:0] percent(int num);
      int p;
      if (total_pk == 0 || num <= 0) return 8'd0;
      p = (100 * num) / int'(total_pk);
      return (p > 100) ? 8'd100 : p[7:0];
   endfunction

   function automatic void progress(logic [7:0] p);
      if (p != prev_pct) put(plt_pkg::KIND_PROGRESS, {8'd0, p});
      prev_pct = p;
   endfunction

   function automatic void complete();
      put(plt_pkg::KIND_PROGRESS, 16'd100);
      put(plt_pkg::KIND_DONE, 16'd100);
      armed = 0;
   endfunction

   function automatic void track_packet(logic [15:0] seq, logic [15:0] total);
      int i;
      int s;
      armed  = 1;
      idle_n = '0;
      if (total_pk == 0) total_pk = total;
      if (seq == 0) return;
      if (resend_on) begin
         for (i = 0; i < loss_n; i++) begin
            if (loss_mem[i] == seq) begin
               resent_n = resent_n + 16'd1;
               put(plt_pkg::KIND_PLACE, seq - 16'd1);
               progress(percent(int'(total_pk) + int'(resent_n) - int'(loss_tot)));
               for (s = i; s < loss_n - 1; s++) loss_mem[s] = loss_mem[s + 1];
               loss_n--;
               break;
            end
         end
         if (resent_n == loss_tot) complete();
         return;
      end
      for (s = int'(last_rx) + 1; s < int'(seq); s++) note_loss(s);
      put(plt_pkg::KIND_PLACE, seq - 16'd1);
      progress(percent(int'(seq) - loss_n));
      last_rx = seq;
      if (seq == total_pk && loss_n == 0) complete();
   endfunction

   function automatic void track_tick();
      int limit;
      int n;
      int i;
      int s;
      int room;
      bit recon;
      limit = (timeout_reg == 0) ? 1 : int'(timeout_reg);
      recon = 0;
      if (!armed) return;
      if (idle_n != 16'hFFFF) idle_n++;
      if (int'(idle_n) < limit) return;
      if (total_pk == 0) begin
         put(plt_pkg::KIND_FAILED, 16'd0);
         armed = 0;
         return;
      end
      if (round_n == plt_pkg::ROUND_NONE) begin
         for (s = int'(last_rx) + 1; s <= int'(total_pk); s++) note_loss(s);
         round_n = '0;
      end else if (round_n < plt_pkg::ROUND_MAX) begin
         round_n++;
      end
      if (loss_n == 0) return;
      if (round_n >= {1'b0, rounds_reg}) begin
         recon   = 1;
         round_n = '0;
         put(plt_pkg::KIND_RECONNECT, 16'd0);
      end
      if (loss_tot == 0) loss_tot = loss_n[15:0];
      n = (loss_n < plt_pkg::RESEND_BATCH_DEF) ? loss_n : plt_pkg::RESEND_BATCH_DEF;
      room = recon ? plt_pkg::MAX_RESULTS - 1 : plt_pkg::MAX_RESULTS;
      if (n > room) n = room;
      for (i = 0; i < n; i++) put(plt_pkg::KIND_RESEND, loss_mem[i]);
      resend_on = 1;
      idle_n    = '0;
   endfunction

   // Works out the results of one accepted transaction into step_q.
   function automatic void track_item(logic [1:0] func, logic [15:0] seq, logic [15:0] total);
      int k;
      step_q.delete();
      case (func)
         plt_pkg::FUNC_PACKET: track_packet(seq, total);
         plt_pkg::FUNC_TICK:   track_tick();
         plt_pkg::FUNC_START:  session_clear();
         default: ;
      endcase
      for (k = 0; k < step_q.size(); k++) begin
         step_q[k].last     = (k == step_q.size() - 1);
         step_q[k].overflow = ovf;
      end
   endfunction

   task automatic send(logic [1:0] func, logic [15:0] seq, logic [15:0] total,
                       bit fixed = 0, int n_fixed = 0,
                       logic [2:0] kind = plt_pkg::KIND_PLACE, logic [15:0] value = '0);
      int gap;
      result_type r;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func  <= func;
      req_seq   <= seq;
      req_total <= total;
      do @(posedge clock); while (!req_ready);
      track_item(func, seq, total);
      if (fixed) begin
         // Expectations typed into the table stand in for the tracker here.
         if (n_fixed == 1) begin
            r.kind     = kind;
            r.value    = value;
            r.last     = 1;
            r.overflow = 0;
            expected_q.insert(expected_q.size(), r);
         end
      end else begin
         foreach (step_q[k]) expected_q.insert(expected_q.size(), step_q[k]);
      end
      items_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_q.size() != 0 || !req_ready) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_regs(logic [15:0] ticks, logic [3:0] rounds);
      csr_we    <= 1'b1;
      csr_index <= plt_pkg::CSR_TIMEOUT_TICKS;
      csr_data  <= ticks;
      @(posedge clock);
      csr_index <= plt_pkg::CSR_MAX_ROUNDS;
      csr_data  <= {12'd0, rounds};
      @(posedge clock);
      csr_we    <= 1'b0;
      timeout_reg = ticks;
      rounds_reg  = rounds;
      @(posedge clock);
   endtask

   task automatic add_row(logic [1:0] func, logic [15:0] seq, logic [15:0] total,
                          bit fixed = 0, int n_fixed = 0,
                          logic [2:0] kind = plt_pkg::KIND_PLACE,
                          logic [15:0] value = '0);
      row_type r;
      r.func = func; r.seq = seq; r.total = total;
      r.fixed = fixed; r.n_fixed = n_fixed; r.kind = kind; r.value = value;
      rows.insert(rows.size(), r);
   endtask

   task automatic random_phase(int target);
      int stop;
      int tot;
      int nxt;
      int r;
      int n;
      int steps;
      logic [15:0] s;
      stop = items_sent + target;
      while (items_sent < stop) begin
         send(plt_pkg::FUNC_START, 16'($urandom_range(0, 65535)),
              16'($urandom_range(0, 65535)));
         tot = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 65535) : $urandom_range(1, 40);
         nxt = 1;
         steps = $urandom_range(8, 24);
         while (steps > 0 && items_sent < stop) begin
            steps--;
            r = $urandom_range(0, 99);
            if (r < 55) begin
               if (resend_on && loss_n > 0 && $urandom_range(0, 3) != 0) begin
                  s = loss_mem[$urandom_range(0, loss_n - 1)];
               end else begin
                  n = nxt + $urandom_range(0, 3);
                  s = (n > 65535) ? 16'hFFFF : n[15:0];
                  nxt = int'(s) + 1;
               end
               send(plt_pkg::FUNC_PACKET, s,
                    ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535)) : tot[15:0]);
            end else if (r < 80) begin
               repeat ($urandom_range(1, 6)) send(plt_pkg::FUNC_TICK,
                                                 16'($urandom_range(0, 65535)),
                                                 16'($urandom_range(0, 65535)));
            end else if (r < 88) begin
               send(plt_pkg::FUNC_PACKET, 16'($urandom_range(1, nxt)), tot[15:0]);
            end else if (r < 92) begin
               send(FUNC_UNUSED, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
            end else if (r < 95) begin
               send(plt_pkg::FUNC_PACKET, 16'd0, 16'($urandom_range(0, 65535)));
            end else if (r < 97) begin
               send(plt_pkg::FUNC_PACKET, 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)));
            end else begin
               send(plt_pkg::FUNC_START, 16'd0, 16'd0);
               nxt = 1;
            end
         end
      end
      settle();
   endtask

   // Result side: checks every accepted transaction and stalls on its own pattern.
   initial begin
      rsp_ready  <= 1'b0;
      hold_cnt   = 0;
      stall_mode = 0;
      mode_left  = 0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result kind %0d value %0d last %0d overflow %0d",
                        $time, rsp_kind, rsp_value, rsp_last, rsp_overflow);
            end else begin
               result_type e;
               e = expected_q.pop_front();
               if (e.kind !== rsp_kind || e.value !== rsp_value ||
                   e.last !== rsp_last || e.overflow !== rsp_overflow) begin
                  errors++;
                  $display("%0t: expected kind/value/last/ovf %0d %0d %0d %0d, got %0d %0d %0d %0d",
                           $time, e.kind, e.value, e.last, e.overflow,
                           rsp_kind, rsp_value, rsp_last, rsp_overflow);
               end
            end
         end
         if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_ready <= 1'b0;
         end else if (pressure_req) begin
            pressure_req = 0;
            hold_cnt     = 600;
            rsp_ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 2);
               mode_left  = $urandom_range(20, 120);
            end
            mode_left--;
            case (stall_mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               default: rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_valid  <= 1'b0;
      req_func   <= plt_pkg::FUNC_PACKET;
      req_seq    <= '0;
      req_total  <= '0;
      csr_we     <= 1'b0;
      csr_index  <= plt_pkg::CSR_TIMEOUT_TICKS;
      csr_data   <= '0;
      errors       = 0;
      burst_left   = 0;
      items_sent   = 0;
      pressure_req = 0;
      timeout_reg  = plt_pkg::TIMEOUT_RESET;
      rounds_reg   = plt_pkg::MAX_ROUNDS_RESET;
      session_clear();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      write_regs(16'd1, 4'd0);
      add_row(plt_pkg::FUNC_START,  16'd0, 16'd0, 1, 0);
      add_row(plt_pkg::FUNC_PACKET, 16'd0, 16'd0, 1, 0);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0, 1, 1, plt_pkg::KIND_FAILED, 16'd0);
      add_row(FUNC_UNUSED,          16'd7, 16'd7, 1, 0);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0, 1, 0);
      add_row(plt_pkg::FUNC_START,  16'd0, 16'd0, 1, 0);
      add_row(plt_pkg::FUNC_PACKET, 16'd1, 16'd4);
      add_row(plt_pkg::FUNC_PACKET, 16'd4, 16'd4);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0);
      add_row(plt_pkg::FUNC_PACKET, 16'd3, 16'd4);
      add_row(plt_pkg::FUNC_PACKET, 16'd9, 16'd4);
      add_row(plt_pkg::FUNC_PACKET, 16'd2, 16'd4);
      add_row(plt_pkg::FUNC_START,  16'd0, 16'd0, 1, 0);
      // A sequence beyond the total leaves its gap in the loss list; the ticks resend it.
      add_row(plt_pkg::FUNC_PACKET, 16'd3, 16'd2);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0);
      add_row(plt_pkg::FUNC_PACKET, 16'd2, 16'd0);
      add_row(plt_pkg::FUNC_START,  16'hFFFF, 16'hFFFF, 1, 0);
      // The widest gap overflows the loss list; the ticks then give full batches.
      add_row(plt_pkg::FUNC_PACKET, 16'hFFFF, 16'hFFFF);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0);
      add_row(plt_pkg::FUNC_TICK,   16'd0, 16'd0);
      add_row(plt_pkg::FUNC_PACKET, 16'd0, 16'd0, 1, 0);
      add_row(plt_pkg::FUNC_PACKET, 16'd1, 16'd0);
      add_row(plt_pkg::FUNC_START,  16'd0, 16'd0, 1, 0);
      foreach (rows[i])
         send(rows[i].func, rows[i].seq, rows[i].total, rows[i].fixed,
              rows[i].n_fixed, rows[i].kind, rows[i].value);
      settle();

      write_regs(16'd2, 4'd3);
      pressure_req = 1;
      random_phase(45);
      write_regs(16'd1, 4'd15);
      random_phase(45);
      write_regs(16'd0, 4'd1);
      random_phase(45);
      write_regs(16'd4, 4'd2);
      random_phase(45);
      write_regs(16'hFFFF, 4'd15);
      random_phase(26);

      if (errors == 0) begin
         $display("packet_loss_tracker_core: match");
      end else begin
         $display("packet_loss_tracker_core: mismatch");
      end
      $finish;
   end

endmodule

[files.f]
rtl/core/plt_pkg.sv
rtl/core/packet_loss_tracker_core.sv
test/tb_packet_loss_tracker_core.sv
